// ===== hw/rtl/utad_pkg.sv =====
`default_nettype none

package utad_pkg;

  // Radix select codes carried in the opcode field
  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 32-bit v
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [6:0] ASCII_ZERO    = 7'd48;
  localparam logic [6:0] ASCII_LOWER_A = 7'd97;

  typedef struct packed {
    logic [31:0] value;
    logic        opcode;
  } in_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new transaction
    logic put_zero;  // store the single digit of a zero value
    logic mul_en;    // form the quotient of the held value
    logic step;      // store the remainder and advance to the quotient
    logic emit;      // move the next digit into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic value_zero;
    logic count_zero;
    logic full;
    logic idx_zero;
    logic out_free;
  } sts_t;

  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] r;
    if (d < 4'd10) begin
      r = ASCII_ZERO + {3'b000, d};
    end else begin
      r = ASCII_LOWER_A + {3'b000, d - 4'd10};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utad_ctrl.sv =====
`default_nettype none

module utad_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  utad_pkg::sts_t       sts_i,
  output utad_pkg::cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUB,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.value_zero && sts_i.count_zero) begin
          cmd_o.put_zero = 1'b1;
          state_d        = ST_EMIT;
        end else if (sts_i.value_zero || sts_i.full) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.mul_en = 1'b1;
          state_d      = ST_SUB;
        end
      end
      ST_SUB: begin
        cmd_o.step = 1'b1;
        state_d    = ST_DIV;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utad_dpath.sv =====
`default_nettype none

module utad_dpath #(
  parameter int unsigned DIGIT_STORE_DEPTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  utad_pkg::in_t        in_data_i,
  input  utad_pkg::cmd_t       cmd_i,
  output utad_pkg::sts_t       sts_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output utad_pkg::out_t       out_data_o
);

  localparam int unsigned CW = $clog2(DIGIT_STORE_DEPTH + 1);
  localparam int unsigned IW = $clog2(DIGIT_STORE_DEPTH);

  logic [31:0]   value_q;
  logic [31:0]   quot_q;
  logic          hex_q;
  logic [CW-1:0] count_q;
  logic [IW-1:0] idx_q;
  logic [3:0]    store_q [DIGIT_STORE_DEPTH];
  logic          out_valid_q;
  utad_pkg::out_t out_q;

  logic [63:0] prod;
  logic [31:0] quot_d;
  logic [3:0]  qmul_lo;
  logic [3:0]  rem;

  // Quotient by reciprocal multiply for decimal, by shift for hex
  assign prod   = 64'(value_q) * 64'(utad_pkg::RECIP_10);
  assign quot_d = hex_q ? (value_q >> 4) : 32'(prod >> utad_pkg::RECIP_SHIFT);

  // Only the low nibble of quotient * radix matters for the remainder
  assign qmul_lo = hex_q ? 4'd0 : 4'((quot_q << 3) + (quot_q << 1));
  assign rem     = value_q[3:0] - qmul_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.load) begin
        value_q <= in_data_i.value;
        count_q <= '0;
      end else if (cmd_i.put_zero) begin
        count_q <= CW'(1);
      end else if (cmd_i.step) begin
        value_q <= quot_q;
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hex_q <= (in_data_i.opcode == utad_pkg::OP_HEX);
    end
    if (cmd_i.mul_en) begin
      quot_q <= quot_d;
    end
    if (cmd_i.put_zero) begin
      store_q[0] <= 4'd0;
      idx_q      <= '0;
    end else if (cmd_i.step) begin
      store_q[count_q[IW-1:0]] <= rem;
      idx_q                    <= count_q[IW-1:0];
    end else if (cmd_i.emit) begin
      idx_q <= idx_q - IW'(1);
    end
    if (cmd_i.emit) begin
      out_q.digit_char <= utad_pkg::digit_to_ascii(store_q[idx_q]);
      out_q.last       <= (idx_q == '0);
    end
  end

  // Output register: hold until taken, refill in the same cycle it drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.value_zero = (value_q == '0);
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.full       = (count_q == CW'(DIGIT_STORE_DEPTH));
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/unsigned_to_ascii_digits.sv =====
// Unsigned 32-bit value to ASCII digit string, decimal or lower-case hex.
// Input channel (in_valid_i / in_ready_o / in_data_i): one transaction holds
// the value and the radix select (opcode 0 decimal, 1 hex).
// Output channel (out_valid_o / out_ready_i / out_data_o): one transaction
// per character, most significant first; last marks the final character.
// A zero value gives the single character '0' with last set.
// Each digit is formed by a shared divide-by-radix step:
// a reciprocal multiply (or shift for hex) into a quotient register, then a
// remainder subtract into the digit store.
// in_ready_o is high only while no conversion is under way; the next value
// may be taken while the final character still waits in the output register.
// A stalled receiver holds the output register and pauses emission.
// Reset clears the controller, the output valid, the held value and the digit count; no clearing pass.
`default_nettype none

module unsigned_to_ascii_digits #(
  parameter int unsigned DIGIT_STORE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  utad_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output utad_pkg::out_t   out_data_o
);

  utad_pkg::cmd_t cmd;
  utad_pkg::sts_t sts;

  utad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  utad_dpath #(
    .DIGIT_STORE_DEPTH (DIGIT_STORE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
